FILE: rtl/ibt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibt_pkg;

    localparam int HANDLE_W          = 64;
    localparam int WORD_W            = 32;
    localparam int ENTRY_W           = 3 * WORD_W;   // layout, access, stage
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Write-type access bits in the default mask
    localparam logic [WORD_W-1:0] ACC_HOST_WRITE   = 32'h0000_0001;
    localparam logic [WORD_W-1:0] ACC_XFER_WRITE   = 32'h0000_0008;
    localparam logic [WORD_W-1:0] ACC_SHADER_WRITE = 32'h0000_0040;
    localparam logic [WORD_W-1:0] ACC_ATTACH_WRITE = 32'h0000_0200;
    localparam logic [WORD_W-1:0] WR_MASK_RESET    =
        ACC_HOST_WRITE | ACC_XFER_WRITE | ACC_SHADER_WRITE | ACC_ATTACH_WRITE;

    // One queued image use, already classified by the front end
    typedef struct packed {
        logic                new_graph;
        logic                null_handle;
        logic [HANDLE_W-1:0] image_handle;
        logic [WORD_W-1:0]   needed_layout;
        logic [WORD_W-1:0]   leaving_layout;
        logic [WORD_W-1:0]   use_access;
        logic [WORD_W-1:0]   use_stage;
    } use_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] barrier_image;
        logic [WORD_W-1:0]   prior_layout;
        logic [WORD_W-1:0]   target_layout;
        logic [WORD_W-1:0]   source_access;
        logic [WORD_W-1:0]   dest_access;
        logic [WORD_W-1:0]   source_stage;
        logic [WORD_W-1:0]   dest_stage;
        logic                table_full;
    } barrier_t;

endpackage

`default_nettype wire

FILE: rtl/ibt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ibt_use_if;
    logic                         valid;
    logic                         ready;
    logic                         new_graph;
    logic [ibt_pkg::HANDLE_W-1:0] image_handle;
    logic [ibt_pkg::WORD_W-1:0]   needed_layout;
    logic [ibt_pkg::WORD_W-1:0]   leaving_layout;
    logic [ibt_pkg::WORD_W-1:0]   use_access;
    logic [ibt_pkg::WORD_W-1:0]   use_stage;

    modport source (output valid, new_graph, image_handle, needed_layout,
                    leaving_layout, use_access, use_stage, input ready);
    modport sink   (input valid, new_graph, image_handle, needed_layout,
                    leaving_layout, use_access, use_stage, output ready);
endinterface

interface ibt_barrier_if;
    logic                         valid;
    logic                         ready;
    logic [ibt_pkg::HANDLE_W-1:0] barrier_image;
    logic [ibt_pkg::WORD_W-1:0]   prior_layout;
    logic [ibt_pkg::WORD_W-1:0]   target_layout;
    logic [ibt_pkg::WORD_W-1:0]   source_access;
    logic [ibt_pkg::WORD_W-1:0]   dest_access;
    logic [ibt_pkg::WORD_W-1:0]   source_stage;
    logic [ibt_pkg::WORD_W-1:0]   dest_stage;
    logic                         table_full;

    modport source (output valid, barrier_image, prior_layout, target_layout,
                    source_access, dest_access, source_stage, dest_stage,
                    table_full, input ready);
    modport sink   (input valid, barrier_image, prior_layout, target_layout,
                    source_access, dest_access, source_stage, dest_stage,
                    table_full, output ready);
endinterface

interface ibt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ibt_pkg::WORD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ibt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ibt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ibt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ibt_use_if.sink            use_in,
    output logic               q_valid,
    input  wire logic          q_ready,
    output ibt_pkg::use_t      q_item
);
    import ibt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    use_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;
    use_t             in_item;

    // classify: null handles are tagged here so the back end skips the lookup
    always_comb
    begin
        in_item.new_graph      = use_in.new_graph;
        in_item.null_handle    = (use_in.image_handle == '0);
        in_item.image_handle   = use_in.image_handle;
        in_item.needed_layout  = use_in.needed_layout;
        in_item.leaving_layout = use_in.leaving_layout;
        in_item.use_access     = use_in.use_access;
        in_item.use_stage      = use_in.use_stage;
    end

    assign use_in.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push         = use_in.valid && use_in.ready;
    assign q_valid      = (count_reg != '0);
    assign pop          = q_valid && q_ready;
    assign q_item       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ibt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ibt_back #(
    parameter int TABLE_ENTRIES = ibt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire ibt_pkg::use_t              q_item,
    input  wire logic [ibt_pkg::WORD_W-1:0] write_access_mask,
    ibt_barrier_if.source                   barrier_out
);
    import ibt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_RESULT
    } state_t;

    state_t                     state_reg;
    use_t                       item_reg;
    logic [TABLE_ENTRIES-1:0]   valid_reg;
    logic [HANDLE_W-1:0]        key_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   match_reg;
    logic [TABLE_ENTRIES-1:0]   free1h_reg;
    logic                       hit_reg;
    logic                       full_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic                       out_valid_reg;
    barrier_t                   out_reg;

    logic [TABLE_ENTRIES-1:0]   valid_eff;
    logic [TABLE_ENTRIES-1:0]   match_c;
    logic [TABLE_ENTRIES-1:0]   free_c;
    logic [TABLE_ENTRIES-1:0]   free1h_c;
    logic                       hit_c;
    logic [IDX_W-1:0]           hit_idx_c;
    logic [IDX_W-1:0]           free_idx_c;
    logic                       take_c;
    logic                       go_c;
    logic                       emit_c;
    logic [ENTRY_W-1:0]         rd_data;
    logic [WORD_W-1:0]          old_l;
    logic [WORD_W-1:0]          src_a;
    logic [WORD_W-1:0]          src_s;

    function automatic logic [IDX_W-1:0] enc1h(input logic [TABLE_ENTRIES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (v[i])
            begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

    // lookup stage: compare all keys, isolate lowest free entry
    always_comb
    begin
        valid_eff = q_item.new_graph ? '0 : valid_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_c[i] = valid_eff[i] && (key_reg[i] == q_item.image_handle);
        end
        free_c   = ~valid_eff;
        free1h_c = free_c & (~free_c + TABLE_ENTRIES'(1));
    end

    // keys are unique, so the hit vector is at most one-hot
    assign hit_c      = |match_reg;
    assign hit_idx_c  = enc1h(match_reg);
    assign free_idx_c = enc1h(free1h_reg);

    assign q_ready = (state_reg == ST_IDLE);
    assign take_c  = q_valid && q_ready;
    assign go_c    = (state_reg == ST_RESULT) && (!out_valid_reg || barrier_out.ready);

    assign old_l = hit_reg ? rd_data[3*WORD_W-1:2*WORD_W] : '0;
    assign src_a = hit_reg ? rd_data[2*WORD_W-1:WORD_W]   : '0;
    assign src_s = hit_reg ? rd_data[WORD_W-1:0]          : '0;

    assign emit_c = !hit_reg || (old_l != item_reg.needed_layout)
                 || (((src_a | item_reg.use_access) & write_access_mask) != '0);

    ibt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (go_c && !full_reg),
        .wr_addr (slot_reg),
        .wr_data ({item_reg.leaving_layout, item_reg.use_access, item_reg.use_stage}),
        .rd_en   (state_reg == ST_ENC),
        .rd_addr (hit_idx_c),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_c)
                    begin
                        if (q_item.new_graph)
                        begin
                            valid_reg <= '0;
                        end
                        if (!q_item.null_handle)
                        begin
                            state_reg <= ST_ENC;
                        end
                    end
                end
                ST_ENC:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (go_c)
                    begin
                        if (!full_reg)
                        begin
                            valid_reg[slot_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (go_c && emit_c)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (barrier_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_c)
        begin
            item_reg   <= q_item;
            match_reg  <= match_c;
            free1h_reg <= free1h_c;
        end
        if (state_reg == ST_ENC)
        begin
            hit_reg  <= hit_c;
            full_reg <= !hit_c && (free1h_reg == '0);
            slot_reg <= hit_c ? hit_idx_c : free_idx_c;
        end
        if (go_c && !full_reg)
        begin
            key_reg[slot_reg] <= item_reg.image_handle;
        end
        if (go_c && emit_c)
        begin
            out_reg.barrier_image <= item_reg.image_handle;
            out_reg.prior_layout  <= old_l;
            out_reg.target_layout <= item_reg.needed_layout;
            out_reg.source_access <= src_a;
            out_reg.dest_access   <= item_reg.use_access;
            out_reg.source_stage  <= src_s;
            out_reg.dest_stage    <= item_reg.use_stage;
            out_reg.table_full    <= full_reg;
        end
    end

    assign barrier_out.valid         = out_valid_reg;
    assign barrier_out.barrier_image = out_reg.barrier_image;
    assign barrier_out.prior_layout  = out_reg.prior_layout;
    assign barrier_out.target_layout = out_reg.target_layout;
    assign barrier_out.source_access = out_reg.source_access;
    assign barrier_out.dest_access   = out_reg.dest_access;
    assign barrier_out.source_stage  = out_reg.source_stage;
    assign barrier_out.dest_stage    = out_reg.dest_stage;
    assign barrier_out.table_full    = out_reg.table_full;

endmodule

`default_nettype wire

FILE: rtl/image_barrier_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Image barrier tracker. Each item on use_in is one use of an image; the block
// keeps a table of TABLE_ENTRIES images (last layout, access and stage) and
// emits at most one barrier item on barrier_out per use: on a first use, a
// layout change, or when the stored or new access hits write_access_mask
// (written through cfg, reset 0x249). A handle of 0 gives no item; new_graph
// wipes the table before the use is looked up. If the table is full, a new
// image still gets a first-use barrier (prior layout, source access and stage
// all 0) with table_full set and is not stored. A nonzero-handle use goes
// through key compare, index encode plus entry RAM read, update and result;
// no new use is taken until its result is done. A null handle skips lookup.
// A 2-item queue sits between input and lookup. While a barrier waits in the
// one-item output register, the next lookup runs up to its result step.
// Config writes are taken every cycle; change the mask only while idle.
module image_barrier_tracker_unit #(
    parameter int TABLE_ENTRIES = ibt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ibt_use_if.sink        use_in,
    ibt_barrier_if.source  barrier_out,
    ibt_cfg_if.sink        cfg
);
    import ibt_pkg::*;

    logic [WORD_W-1:0] mask_reg;
    logic              q_valid;
    logic              q_ready;
    use_t              q_item;

    // mask register: always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= WR_MASK_RESET;
        end
        else if (cfg.valid)
        begin
            mask_reg <= cfg.data;
        end
    end

    // front: accept and classify, queue
    ibt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .use_in  (use_in),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // back: table lookup, update, barrier output register
    ibt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_item            (q_item),
        .write_access_mask (mask_reg),
        .barrier_out       (barrier_out)
    );

    // a table-full barrier is always a first-use barrier
    a_full_is_first_use: assert property (@(posedge clk) disable iff (!rst_n)
        (barrier_out.valid && barrier_out.table_full) |->
            (barrier_out.prior_layout == '0 && barrier_out.source_access == '0
             && barrier_out.source_stage == '0))
        else $error("table_full barrier carries previous-use state");

    // null handles never produce a barrier
    a_no_null_barrier: assert property (@(posedge clk) disable iff (!rst_n)
        barrier_out.valid |-> (barrier_out.barrier_image != '0))
        else $error("barrier emitted for null image handle");

    // mask only changes on a config write
    a_mask_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg.valid && cfg.ready) |=> $stable(mask_reg))
        else $error("write mask changed without a config write");

endmodule

`default_nettype wire
